// File: hw/rtl/sha512_pkg.sv
// shared types, constants and sigma functions of the sha-512 message hasher
package sha512_pkg;

  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  valid_bytes;
    logic        last_word;
  } in_item_t;

  typedef struct packed {
    logic [63:0] hash_word;
    logic [2:0]  word_index;
    logic        last;
  } out_item_t;

  // element 0 is a, element 7 is h
  typedef logic [7:0][63:0] hash_vec_t;

  typedef struct packed {
    logic shift;  // advance the schedule line by one word
    logic ext;    // shift in an external word instead of an expanded one
  } sched_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_FINAL,
    ST_DONE
  } state_e;

  localparam int unsigned Rounds = 80;
  localparam logic [6:0] LastRound = 7'(Rounds - 1);

  localparam logic [63:0] PadMarker = 64'h8000_0000_0000_0000;

  localparam hash_vec_t InitHash = {
    64'h5be0cd19137e2179, 64'h1f83d9abfb41bd6b, 64'h9b05688c2b3e6c1f, 64'h510e527fade682d1,
    64'ha54ff53a5f1d36f1, 64'h3c6ef372fe94f82b, 64'hbb67ae8584caa73b, 64'h6a09e667f3bcc908
  };

  localparam logic [63:0] RoundK [Rounds] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic logic [63:0] big_sigma0(logic [63:0] x);
    return {x[27:0], x[63:28]} ^ {x[33:0], x[63:34]} ^ {x[38:0], x[63:39]};
  endfunction

  function automatic logic [63:0] big_sigma1(logic [63:0] x);
    return {x[13:0], x[63:14]} ^ {x[17:0], x[63:18]} ^ {x[40:0], x[63:41]};
  endfunction

  function automatic logic [63:0] small_sigma0(logic [63:0] x);
    return {x[0], x[63:1]} ^ {x[7:0], x[63:8]} ^ {7'b0, x[63:7]};
  endfunction

  function automatic logic [63:0] small_sigma1(logic [63:0] x);
    return {x[18:0], x[63:19]} ^ {x[60:0], x[63:61]} ^ {6'b0, x[63:6]};
  endfunction

endpackage

// File: hw/rtl/sha512_round.sv
// one sha-512 compression round over the working words
module sha512_round (
  input  sha512_pkg::hash_vec_t work_i,
  input  logic [63:0]           kw_i,
  output sha512_pkg::hash_vec_t work_o
);

  logic [63:0] ch, maj, t1, t2;

  always_comb begin
    ch  = (work_i[4] & work_i[5]) ^ (~work_i[4] & work_i[6]);
    maj = (work_i[0] & work_i[1]) ^ (work_i[0] & work_i[2]) ^ (work_i[1] & work_i[2]);
    // kw_i already holds round constant plus schedule word
    t1  = work_i[7] + sha512_pkg::big_sigma1(work_i[4]) + ch + kw_i;
    t2  = sha512_pkg::big_sigma0(work_i[0]) + maj;

    work_o[7] = work_i[6];
    work_o[6] = work_i[5];
    work_o[5] = work_i[4];
    work_o[4] = work_i[3] + t1;
    work_o[3] = work_i[2];
    work_o[2] = work_i[1];
    work_o[1] = work_i[0];
    work_o[0] = t1 + t2;
  end

endmodule

// File: hw/rtl/sha512_sched.sv
// sixteen-word message schedule shift line with in-place expansion
module sha512_sched (
  input  logic                    clk_i,
  input  sha512_pkg::sched_ctrl_t ctrl_i,
  input  logic [63:0]             word_i,
  output logic [63:0]             w0_o
);

  logic [15:0][63:0] w_q;
  logic [63:0]       expand_word;
  logic [63:0]       shift_in;

  // w_q[0] is the word of the current round
  assign expand_word = w_q[0] + sha512_pkg::small_sigma0(w_q[1]) + w_q[9]
                     + sha512_pkg::small_sigma1(w_q[14]);
  assign shift_in    = ctrl_i.ext ? word_i : expand_word;
  assign w0_o        = w_q[0];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      w_q <= {shift_in, w_q[15:1]};
    end
  end

endmodule

// File: hw/rtl/sha512_message_hasher.sv
// top level of the sha-512 message hasher: sequencer, chaining words and digest buffer
// input words are taken while idle; the sixteenth word of a block starts a compression
// (one load, 80 rounds of the shared round unit, one chaining add) while input stalls
// a last word adds one pad word per cycle up to the block end plus one or two compressions,
// then the digest moves in once the output buffer is free; eight digest transactions follow
// reset: chaining words to the initial hash values, counters cleared, output buffer empty
module sha512_message_hasher (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  sha512_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output sha512_pkg::out_item_t out_data_o
);

  // sequencer state
  sha512_pkg::state_e state_q, state_d;
  logic [6:0]         round_q, round_d;
  logic [3:0]         pos_q, pos_d;       // next word slot in the block
  logic [63:0]        count_q, count_d;   // message bytes, wraps mod 2^64
  logic               pad80_q, pad80_d;   // full last word: marker word still owed
  logic               hi_q, hi_d;         // upper length word pushed, lower one next
  logic               len_q, len_d;       // length pushed, digest due after compression
  logic               pading_q, pading_d; // message ended, padding in progress

  // datapath
  sha512_pkg::hash_vec_t chain_q, chain_d;
  sha512_pkg::hash_vec_t work_q, work_d;
  sha512_pkg::hash_vec_t work_next;
  logic [63:0]           kw_q, kw_d;

  // output buffer
  sha512_pkg::hash_vec_t digest_q, digest_d;
  logic                  busy_q, busy_d;
  logic [2:0]            idx_q, idx_d;

  // schedule interface
  sha512_pkg::sched_ctrl_t sched_ctrl;
  logic                    push;
  logic [63:0]             push_word;
  logic [63:0]             w0;
  logic [6:0]              kidx;

  // last-word handling
  logic [3:0]  nbytes;
  logic [5:0]  tail_shift;
  logic [63:0] keep_mask;
  logic [63:0] tail_word;
  logic        in_take;
  logic        out_take;

  assign in_take  = in_valid_i && !in_stall_o;
  assign out_take = out_valid_o && !out_stall_i;

  // byte counts above eight count as eight
  assign nbytes     = (in_data_i.valid_bytes > 4'd8) ? 4'd8 : in_data_i.valid_bytes;
  assign tail_shift = {nbytes[2:0], 3'b000};
  assign keep_mask  = ~({64{1'b1}} >> tail_shift);
  assign tail_word  = (in_data_i.data_word & keep_mask) | (sha512_pkg::PadMarker >> tail_shift);

  // round constant for the round after this one, paired with the word now at the head
  assign kidx = (state_q == sha512_pkg::ST_ROUND && round_q != sha512_pkg::LastRound)
              ? round_q + 7'd1 : 7'd0;
  assign kw_d = sha512_pkg::RoundK[kidx] + w0;

  assign sched_ctrl.ext   = push;
  assign sched_ctrl.shift = push || state_q == sha512_pkg::ST_LOAD
                         || state_q == sha512_pkg::ST_ROUND;

  sha512_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sched_ctrl),
    .word_i (push_word),
    .w0_o   (w0)
  );

  sha512_round u_round (
    .work_i (work_q),
    .kw_i   (kw_q),
    .work_o (work_next)
  );

  assign in_stall_o            = state_q != sha512_pkg::ST_IDLE;
  assign out_valid_o           = busy_q;
  assign out_data_o.hash_word  = digest_q[idx_q];
  assign out_data_o.word_index = idx_q;
  assign out_data_o.last       = idx_q == 3'd7;

  always_comb begin
    state_d   = state_q;
    round_d   = round_q;
    pos_d     = pos_q;
    count_d   = count_q;
    pad80_d   = pad80_q;
    hi_d      = hi_q;
    len_d     = len_q;
    pading_d  = pading_q;
    chain_d   = chain_q;
    work_d    = work_q;
    digest_d  = digest_q;
    busy_d    = busy_q;
    idx_d     = idx_q;
    push      = 1'b0;
    push_word = '0;

    // digest drains independently of the engine
    if (out_take) begin
      idx_d = idx_q + 3'd1;
      if (idx_q == 3'd7) begin
        busy_d = 1'b0;
      end
    end

    case (state_q)
      sha512_pkg::ST_IDLE: begin
        if (in_take) begin
          push  = 1'b1;
          pos_d = pos_q + 4'd1;
          if (!in_data_i.last_word) begin
            push_word = in_data_i.data_word;
            count_d   = count_q + 64'd8;
          end else begin
            count_d  = count_q + {60'd0, nbytes};
            pading_d = 1'b1;
            if (nbytes == 4'd8) begin
              // marker goes into a word of its own
              push_word = in_data_i.data_word;
              pad80_d   = 1'b1;
            end else begin
              push_word = tail_word;
            end
          end
          if (pos_q == 4'd15) begin
            state_d = sha512_pkg::ST_LOAD;
          end else if (in_data_i.last_word) begin
            state_d = sha512_pkg::ST_PAD;
          end
        end
      end
      sha512_pkg::ST_PAD: begin
        push  = 1'b1;
        pos_d = pos_q + 4'd1;
        if (pad80_q) begin
          push_word = sha512_pkg::PadMarker;
          pad80_d   = 1'b0;
        end else if (hi_q) begin
          // lower half of the 128-bit bit length
          push_word = {count_q[60:0], 3'b000};
          hi_d      = 1'b0;
          len_d     = 1'b1;
        end else if (pos_q == 4'd14) begin
          push_word = {61'd0, count_q[63:61]};
          hi_d      = 1'b1;
        end
        if (pos_q == 4'd15) begin
          state_d = sha512_pkg::ST_LOAD;
        end
      end
      sha512_pkg::ST_LOAD: begin
        work_d  = chain_q;
        round_d = '0;
        state_d = sha512_pkg::ST_ROUND;
      end
      sha512_pkg::ST_ROUND: begin
        work_d  = work_next;
        round_d = round_q + 7'd1;
        if (round_q == sha512_pkg::LastRound) begin
          round_d = '0;
          state_d = sha512_pkg::ST_FINAL;
        end
      end
      sha512_pkg::ST_FINAL: begin
        for (int i = 0; i < 8; i++) begin
          chain_d[i] = chain_q[i] + work_q[i];
        end
        if (len_q) begin
          state_d = sha512_pkg::ST_DONE;
        end else if (pading_q) begin
          state_d = sha512_pkg::ST_PAD;
        end else begin
          state_d = sha512_pkg::ST_IDLE;
        end
      end
      sha512_pkg::ST_DONE: begin
        // wait for the previous digest to drain, then hand over and restart
        if (!busy_q) begin
          digest_d = chain_q;
          busy_d   = 1'b1;
          idx_d    = '0;
          chain_d  = sha512_pkg::InitHash;
          pos_d    = '0;
          count_d  = '0;
          len_d    = 1'b0;
          pading_d = 1'b0;
          state_d  = sha512_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sha512_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sha512_pkg::ST_IDLE;
      round_q  <= '0;
      pos_q    <= '0;
      count_q  <= '0;
      pad80_q  <= 1'b0;
      hi_q     <= 1'b0;
      len_q    <= 1'b0;
      pading_q <= 1'b0;
      chain_q  <= sha512_pkg::InitHash;
      busy_q   <= 1'b0;
      idx_q    <= '0;
    end else begin
      state_q  <= state_d;
      round_q  <= round_d;
      pos_q    <= pos_d;
      count_q  <= count_d;
      pad80_q  <= pad80_d;
      hi_q     <= hi_d;
      len_q    <= len_d;
      pading_q <= pading_d;
      chain_q  <= chain_d;
      busy_q   <= busy_d;
      idx_q    <= idx_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    work_q   <= work_d;
    kw_q     <= kw_d;
    digest_q <= digest_d;
  end

  // round counter never passes the last round
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    round_q <= sha512_pkg::LastRound)
    else $error("round counter out of range");

  // a compression only starts on a full block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sha512_pkg::ST_LOAD |-> pos_q == 4'd0)
    else $error("compression started on a partial block");

  // no padding bookkeeping is left over while taking message words
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sha512_pkg::ST_IDLE |-> !pading_q && !len_q && !hi_q && !pad80_q)
    else $error("stale padding state in idle");

  // the eighth digest transaction empties the output buffer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && idx_q == 3'd7 |=> !out_valid_o)
    else $error("digest buffer not released after final word");

  // length pushed means the next compression ends in a digest hand-over
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sha512_pkg::ST_FINAL && len_q |=> state_q == sha512_pkg::ST_DONE)
    else $error("digest hand-over skipped");

endmodule
